>>> hw/rtl/atrp_pkg.sv
// shared types and constants for the modem reply parser
`default_nettype none

package atrp_pkg;

  localparam int BYTE_W   = 8;
  localparam int RLINE_W  = 3;
  localparam int RCOL_W   = 7;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

  // item kinds on the request channel
  localparam logic FUNC_FEED = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_PENDING = 2'd0,
    STATUS_DONE    = 2'd1,
    STATUS_BAD     = 2'd2
  } status_t;

  // reply byte values
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_O     = 8'h4F;
  localparam logic [BYTE_W-1:0] CH_K     = 8'h4B;
  localparam logic [BYTE_W-1:0] CH_E     = 8'h45;
  localparam logic [BYTE_W-1:0] CH_R     = 8'h52;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] PRINT_LO = 8'd32;
  localparam logic [BYTE_W-1:0] PRINT_HI = 8'd126;

  // queue between classifier and parser
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // classified word as it travels through the queue
  typedef struct packed {
    logic               func;
    logic [BYTE_W-1:0]  data;
    logic               is_cr;
    logic               is_lf;
    logic               is_o;
    logic               is_k;
    logic               is_e;
    logic               is_r;
    logic               is_plus;
    logic               is_print;
    logic               rd_ok;
    logic [RLINE_W-1:0] read_line;
    logic [RCOL_W-1:0]  read_col;
  } item_t;

endpackage

`default_nettype wire

>>> hw/rtl/atrp_if.sv
// request and response channel interfaces of the modem reply parser
`default_nettype none

interface atrp_req_if;
  logic                             valid;
  logic                             ready;
  logic                             func;
  logic [atrp_pkg::BYTE_W-1:0]      byte_in;
  logic [atrp_pkg::RLINE_W-1:0]     read_line;
  logic [atrp_pkg::RCOL_W-1:0]      read_col;

  modport source (output valid, func, byte_in, read_line, read_col, input ready);
  modport sink   (input valid, func, byte_in, read_line, read_col, output ready);
endinterface

interface atrp_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [atrp_pkg::STATUS_W-1:0]    status;
  logic                             final_word;
  logic [atrp_pkg::COUNT_W-1:0]     line_count;
  logic [atrp_pkg::BYTE_W-1:0]      read_char;

  modport source (output valid, status, final_word, line_count, read_char, input ready);
  modport sink   (input valid, status, final_word, line_count, read_char, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/atrp_front.sv
// front end: accepts request words and classifies each reply byte
`default_nettype none

module atrp_front #(
  parameter int MAX_LINES = 8,
  parameter int LINE_SIZE = 128
) (
  atrp_req_if.sink         req,
  input  wire logic        q_full,
  output atrp_pkg::item_t  push_item,
  output logic             push
);

  logic [atrp_pkg::BYTE_W-1:0] b;

  assign b         = req.byte_in;
  assign req.ready = !q_full;
  assign push      = req.valid && !q_full;

  always_comb begin
    push_item           = '0;
    push_item.func      = req.func;
    push_item.data      = b;
    push_item.is_cr     = (b == atrp_pkg::CH_CR);
    push_item.is_lf     = (b == atrp_pkg::CH_LF);
    push_item.is_o      = (b == atrp_pkg::CH_O);
    push_item.is_k      = (b == atrp_pkg::CH_K);
    push_item.is_e      = (b == atrp_pkg::CH_E);
    push_item.is_r      = (b == atrp_pkg::CH_R);
    push_item.is_plus   = (b == atrp_pkg::CH_PLUS);
    push_item.is_print  = (b >= atrp_pkg::PRINT_LO) && (b <= atrp_pkg::PRINT_HI);
    // reads outside the store answer zero
    push_item.rd_ok     = (32'(req.read_line) < MAX_LINES) &&
                          (32'(req.read_col) < LINE_SIZE);
    push_item.read_line = req.read_line;
    push_item.read_col  = req.read_col;
  end

endmodule

`default_nettype wire

>>> hw/rtl/atrp_queue.sv
// short queue of classified words between front end and parser
`default_nettype none

module atrp_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  atrp_pkg::item_t       push_item,
  input  wire logic             pop,
  output atrp_pkg::item_t       head,
  output logic                  full,
  output logic                  empty
);

  atrp_pkg::item_t                  slots [atrp_pkg::QUEUE_DEPTH];
  logic [atrp_pkg::QPTR_W-1:0]      wr_ptr;
  logic [atrp_pkg::QPTR_W-1:0]      rd_ptr;
  logic [atrp_pkg::QCNT_W-1:0]      count;

  assign full  = (32'(count) == atrp_pkg::QUEUE_DEPTH);
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/atrp_back.sv
// back end: reply state machine, line store and response register
`default_nettype none

module atrp_back #(
  parameter int MAX_LINES = 8,
  parameter int LINE_SIZE = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  atrp_pkg::item_t  item,
  input  wire logic        q_empty,
  output logic             pop,
  atrp_rsp_if.source       rsp
);

  localparam int COL_W  = $clog2(LINE_SIZE);
  localparam int DEPTH  = MAX_LINES * LINE_SIZE;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [17:0] {
    S_START    = 18'd1,
    S_LF1      = 18'd2,
    S_BODY     = 18'd4,
    S_OK_K     = 18'd8,
    S_OK_CR    = 18'd16,
    S_OK_LF    = 18'd32,
    S_ER_R1    = 18'd64,
    S_ER_R2    = 18'd128,
    S_ER_O     = 18'd256,
    S_ER_R3    = 18'd512,
    S_ER_CR    = 18'd1024,
    S_ER_LF    = 18'd2048,
    S_INFO0    = 18'd4096,
    S_INFO     = 18'd8192,
    S_INFO_LF  = 18'd16384,
    S_AFTER    = 18'd32768,
    S_BLANK_LF = 18'd65536,
    S_FINAL    = 18'd131072
  } pstate_t;

  pstate_t                         state;
  pstate_t                         state_next;
  logic [COL_W-1:0]                column_count;
  logic [COL_W-1:0]                column_count_next;
  logic [atrp_pkg::COUNT_W-1:0]    lines_seen;
  logic [atrp_pkg::COUNT_W-1:0]    lines_seen_next;
  logic [atrp_pkg::COUNT_W-1:0]    lines_upd;
  logic [atrp_pkg::COUNT_W-1:0]    lines_bumped;

  logic bad, done, err_word, store_req, term_req, bump, col_clr;
  logic store_room, col_room, store_wr, term_wr, is_feed;
  atrp_pkg::status_t               status_code;

  logic [atrp_pkg::BYTE_W-1:0]     store_mem [DEPTH];
  logic [ADDR_W-1:0]               mem_addr;
  logic [ADDR_W-1:0]               wr_addr;
  logic [ADDR_W-1:0]               rd_addr;
  logic                            wr_en;
  logic [atrp_pkg::BYTE_W-1:0]     wr_data;

  logic                            out_valid;
  logic [atrp_pkg::STATUS_W-1:0]   out_status;
  logic                            out_final;
  logic [atrp_pkg::COUNT_W-1:0]    out_count;
  logic [atrp_pkg::BYTE_W-1:0]     out_char;

  assign pop     = !q_empty && (!out_valid || rsp.ready);
  assign is_feed = (item.func == atrp_pkg::FUNC_FEED);

  assign store_room   = (32'(lines_seen) < MAX_LINES);
  assign col_room     = (32'(column_count) < (LINE_SIZE - 1));
  assign lines_bumped = (lines_seen == atrp_pkg::COUNT_MAX) ? lines_seen
                                                            : lines_seen + 1'b1;

  // parse one byte
  always_comb begin
    state_next = state;
    bad        = 1'b0;
    done       = 1'b0;
    err_word   = 1'b0;
    store_req  = 1'b0;
    term_req   = 1'b0;
    bump       = 1'b0;
    col_clr    = 1'b0;
    if (is_feed) begin
      case (state)
        S_START: begin
          if (item.is_cr) begin
            col_clr    = 1'b1;
            state_next = S_LF1;
          end else bad = 1'b1;
        end
        S_LF1: begin
          if (item.is_lf) begin
            bump       = 1'b1;
            col_clr    = 1'b1;
            state_next = S_BODY;
          end else bad = 1'b1;
        end
        S_BODY: begin
          if (item.is_o) state_next = S_OK_K;
          else if (item.is_e) state_next = S_ER_R1;
          else if (item.is_plus) state_next = S_INFO0;
          else bad = 1'b1;
        end
        S_OK_K: begin
          if (item.is_k) state_next = S_OK_CR; else bad = 1'b1;
        end
        S_OK_CR: begin
          if (item.is_cr) state_next = S_OK_LF; else bad = 1'b1;
        end
        S_ER_R1: begin
          if (item.is_r) state_next = S_ER_R2; else bad = 1'b1;
        end
        S_ER_R2: begin
          if (item.is_r) state_next = S_ER_O; else bad = 1'b1;
        end
        S_ER_O: begin
          if (item.is_o) state_next = S_ER_R3; else bad = 1'b1;
        end
        S_ER_R3: begin
          if (item.is_r) state_next = S_ER_CR; else bad = 1'b1;
        end
        S_ER_CR: begin
          if (item.is_cr) state_next = S_ER_LF; else bad = 1'b1;
        end
        S_OK_LF, S_ER_LF: begin
          if (item.is_lf) begin
            bump     = 1'b1;
            done     = 1'b1;
            err_word = (state == S_ER_LF);
          end else bad = 1'b1;
        end
        S_INFO0: begin
          if (item.is_print) begin
            store_req  = 1'b1;
            state_next = S_INFO;
          end else bad = 1'b1;
        end
        S_INFO: begin
          if (item.is_print) begin
            store_req = 1'b1;
          end else if (item.is_cr) begin
            // terminator and line count only while the store has room
            if (store_room) begin
              term_req = 1'b1;
              bump     = 1'b1;
              col_clr  = 1'b1;
            end
            state_next = S_INFO_LF;
          end else bad = 1'b1;
        end
        S_INFO_LF: begin
          if (item.is_lf) state_next = S_AFTER; else bad = 1'b1;
        end
        S_AFTER: begin
          if (item.is_plus) state_next = S_INFO0;
          else if (item.is_cr) state_next = S_BLANK_LF;
          else bad = 1'b1;
        end
        S_BLANK_LF: begin
          if (item.is_lf) state_next = S_FINAL; else bad = 1'b1;
        end
        S_FINAL: begin
          if (item.is_o) state_next = S_OK_K;
          else if (item.is_e) state_next = S_ER_R1;
          else bad = 1'b1;
        end
        default: bad = 1'b1;
      endcase
    end
  end

  assign store_wr  = store_req && store_room && col_room;
  assign term_wr   = term_req;
  assign lines_upd = bump ? lines_bumped : lines_seen;

  // count updates, with the return to start on complete or malformed
  always_comb begin
    if (bad || done) begin
      column_count_next = '0;
      lines_seen_next   = '0;
    end else begin
      lines_seen_next = lines_upd;
      if (col_clr) begin
        column_count_next = '0;
      end else if (store_wr) begin
        column_count_next = column_count + COL_W'(1);
      end else begin
        column_count_next = column_count;
      end
    end
  end

  always_comb begin
    if (bad) begin
      status_code = atrp_pkg::STATUS_BAD;
    end else if (done) begin
      status_code = atrp_pkg::STATUS_DONE;
    end else begin
      status_code = atrp_pkg::STATUS_PENDING;
    end
  end

  // store addressing: row by line count, column by stored bytes
  assign wr_addr  = ADDR_W'(32'(lines_seen) * LINE_SIZE + 32'(column_count));
  assign rd_addr  = ADDR_W'(32'(item.read_line) * LINE_SIZE + 32'(item.read_col));
  assign mem_addr = is_feed ? wr_addr : rd_addr;
  assign wr_en    = pop && is_feed && (store_wr || term_wr);
  assign wr_data  = term_wr ? '0 : item.data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[mem_addr] <= wr_data;
    end
    if (pop) begin
      out_char <= (!is_feed && item.rd_ok) ? store_mem[mem_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_status <= status_code;
      out_final  <= done && err_word;
      out_count  <= lines_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_START;
      column_count <= '0;
      lines_seen   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (pop && is_feed) begin
        state        <= (bad || done) ? S_START : state_next;
        column_count <= column_count_next;
        lines_seen   <= lines_seen_next;
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.final_word = out_final;
  assign rsp.line_count = out_count;
  assign rsp.read_char  = out_char;

endmodule

`default_nettype wire

>>> hw/rtl/at_response_parser.sv
// top level of the modem command reply parser
//
// req channel: one word per item; func 0 feeds one reply byte (byte_in),
// func 1 reads one stored info-line byte at read_line / read_col
// rsp channel: exactly one word per request word, in request order:
// status (pending, complete, malformed), final_word (OK or ERROR on
// complete), line_count after the byte, read_char for reads
// info lines starting with '+' land in the line store, one row per line,
// zero terminated, at most LINE_SIZE-1 bytes kept per line
// the front end classifies bytes and writes a four-word queue; the back
// end runs the reply state machine, the line store and the rsp register
// throughput: one word per cycle unless rsp.ready stalls, set by the state
// step per word and the one store port (one write or one read per word)
// a request word goes into a queue slot and then into the rsp register
// before it shows on rsp
// rsp.ready low holds the rsp register; req keeps being accepted until
// the queue fills, then req.ready drops
// reset: parser goes back to awaiting the first CR, counts and queue are
// cleared; the line store is not cleared and keeps unknown contents
`default_nettype none

module at_response_parser #(
  parameter int MAX_LINES = 8,
  parameter int LINE_SIZE = 128
) (
  input  wire logic   clk,
  input  wire logic   rst,
  atrp_req_if.sink    req,
  atrp_rsp_if.source  rsp
);

  atrp_pkg::item_t  push_item;
  atrp_pkg::item_t  head;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;

  // classify incoming words
  atrp_front #(
    .MAX_LINES (MAX_LINES),
    .LINE_SIZE (LINE_SIZE)
  ) u_front (
    .req       (req),
    .q_full    (q_full),
    .push_item (push_item),
    .push      (push)
  );

  // decouple front end from parser stalls
  atrp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // parse, store and respond
  atrp_back #(
    .MAX_LINES (MAX_LINES),
    .LINE_SIZE (LINE_SIZE)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .item    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire

>>> verif/tb_at_response_parser.sv
// self-checking testbench for the modem reply parser: directed table, directed replies, then random replies
module tb_at_response_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import atrp_pkg::*;

  localparam int MAX_LINES       = 8;
  localparam int LINE_SIZE       = 128;
  localparam int STORE_DEPTH     = MAX_LINES * LINE_SIZE;
  localparam int RANDOM_WORDS    = 650;
  localparam int RSP_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 20;
  localparam int MAX_REPORTS     = 10;
  localparam int TIMEOUT_NS      = 10_000_000;
  localparam int DIR_ROWS        = 25;

  // reply parser states, numbered as the parser walks a reply
  typedef enum logic [4:0] {
    PS_AWAIT_CR   = 5'd0,
    PS_AWAIT_LF   = 5'd1,
    PS_HEAD       = 5'd2,
    PS_OK_K       = 5'd3,
    PS_OK_CR      = 5'd4,
    PS_OK_LF      = 5'd5,
    PS_ERR_R1     = 5'd7,
    PS_ERR_R2     = 5'd8,
    PS_ERR_O      = 5'd9,
    PS_ERR_R3     = 5'd10,
    PS_ERR_CR     = 5'd11,
    PS_ERR_LF     = 5'd12,
    PS_INFO_FIRST = 5'd14,
    PS_INFO_BODY  = 5'd15,
    PS_INFO_LF    = 5'd16,
    PS_AFTER_INFO = 5'd17,
    PS_BLANK_LF   = 5'd18,
    PS_TAIL       = 5'd19
  } parse_state_t;

  typedef struct packed {
    logic               func;
    logic [BYTE_W-1:0]  byte_in;
    logic [RLINE_W-1:0] read_line;
    logic [RCOL_W-1:0]  read_col;
  } req_word_t;

  typedef struct packed {
    status_t            status;
    logic               final_word;
    logic [COUNT_W-1:0] line_count;
    logic [BYTE_W-1:0]  read_char;
  } rsp_word_t;

  typedef struct packed {
    req_word_t w;
    logic      has_fixed;
    rsp_word_t r;
  } dir_row_t;

  localparam rsp_word_t NO_FIXED = '{STATUS_PENDING, 1'b0, 6'd0, 8'h00};

  // directed replies: a bad first byte, one ERROR reply with a single info line
  // of the printable extremes, two reads of that line, then a bare OK reply;
  // only the outcome words that are obvious carry a typed answer
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{'{FUNC_FEED, 8'hFF,    3'd0, 7'd0}, 1'b1, '{STATUS_BAD, 1'b0, 6'd0, 8'h00}},
    '{'{FUNC_FEED, CH_CR,    3'd0, 7'd0}, 1'b0, NO_FIXED},
    '{'{FUNC_FEED, CH_LF,    3'd0, 7'd0}, 1'b1, '{STATUS_PENDING, 1'b0, 6'd1, 8'h00}},
    '{'{FUNC_FEED, CH_PLUS,  3'd0, 7'd0}, 1'b0, NO_FIXED},
    '{'{FUNC_FEED, PRINT_LO, 3'd0, 7'd0}, 1'b0, NO_FIXED},
    '{'{FUNC_FEED, PRINT_HI, 3'd0, 7'd0}, 1'b0, NO_FIXED},
    '{'{FUNC_FEED, CH_CR,    3'd0, 7'd0}, 1'b0, NO_FIXED},
    '{'{FUNC_FEED, CH_LF,    3'd0, 7'd0}, 1'b0, NO_FIXED},
    '{'{FUNC_FEED, CH_CR,    3'd0, 7'd0}, 1'b0, NO_FIXED},
    '{'{FUNC_FEED, CH_LF,    3'd0, 7'd0}, 1'b0, NO_FIXED},
    '{'{FUNC_FEED, CH_E,     3'd0, 7'd0}, 1'b0, NO_FIXED},
    '{'{FUNC_FEED, CH_R,     3'd0, 7'd0}, 1'b0, NO_FIXED},
    '{'{FUNC_FEED, CH_R,     3'd0, 7'd0}, 1'b0, NO_FIXED},
    '{'{FUNC_FEED, CH_O,     3'd0, 7'd0}, 1'b0, NO_FIXED},
    '{'{FUNC_FEED, CH_R,     3'd0, 7'd0}, 1'b0, NO_FIXED},
    '{'{FUNC_FEED, CH_CR,    3'd0, 7'd0}, 1'b0, NO_FIXED},
    '{'{FUNC_FEED, CH_LF,    3'd0, 7'd0}, 1'b1, '{STATUS_DONE, 1'b1, 6'd3, 8'h00}},
    '{'{FUNC_READ, 8'h00,    3'd1, 7'd0}, 1'b0, NO_FIXED},
    '{'{FUNC_READ, 8'h00,    3'd1, 7'd2}, 1'b0, NO_FIXED},
    '{'{FUNC_FEED, CH_CR,    3'd0, 7'd0}, 1'b0, NO_FIXED},
    '{'{FUNC_FEED, CH_LF,    3'd0, 7'd0}, 1'b0, NO_FIXED},
    '{'{FUNC_FEED, CH_O,     3'd0, 7'd0}, 1'b0, NO_FIXED},
    '{'{FUNC_FEED, CH_K,     3'd0, 7'd0}, 1'b0, NO_FIXED},
    '{'{FUNC_FEED, CH_CR,    3'd0, 7'd0}, 1'b0, NO_FIXED},
    '{'{FUNC_FEED, CH_LF,    3'd0, 7'd0}, 1'b1, '{STATUS_DONE, 1'b0, 6'd2, 8'h00}}
  };

  logic clk;
  logic rst;

  atrp_req_if req_ch ();
  atrp_rsp_if rsp_ch ();

  at_response_parser #(
    .MAX_LINES (MAX_LINES),
    .LINE_SIZE (LINE_SIZE)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // predictor copy of the parser: state, counts and the line store
  parse_state_t       ps        = PS_AWAIT_CR;
  logic [RCOL_W-1:0]  col_cnt   = '0;
  logic [COUNT_W-1:0] lines_cnt = '0;
  logic [BYTE_W-1:0]  line_mem     [STORE_DEPTH];
  bit                 line_written [STORE_DEPTH];
  int                 written_idx  [$];   // store entries that reads may target

  rsp_word_t answers_due [$];             // parser answers not yet seen on rsp
  bit        sender_gaps;
  bit        rsp_hold_req;                // asks the receiver for one long hold-off
  int        words_sent;
  int        mismatches;

  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("** at_response_parser: FAILED **");
    $finish;
  end

  // line count stops at its top value
  function automatic void bump_lines();
    if (lines_cnt != COUNT_MAX) lines_cnt = lines_cnt + 1'b1;
  endfunction

  function automatic void put_store(input int idx, input logic [BYTE_W-1:0] v);
    line_mem[idx] = v;
    if (!line_written[idx]) begin
      line_written[idx] = 1'b1;
      written_idx.push_back(idx);
    end
  endfunction

  // info byte lands in the current row while row and store have room;
  // the column only moves for bytes actually kept
  function automatic void keep_info_byte(input logic [BYTE_W-1:0] c);
    if (lines_cnt < MAX_LINES && col_cnt < LINE_SIZE - 1) begin
      put_store(int'(lines_cnt) * LINE_SIZE + int'(col_cnt), c);
      col_cnt = col_cnt + 1'b1;
    end
  endfunction

  function automatic bit is_text(input logic [BYTE_W-1:0] c);
    return c >= PRINT_LO && c <= PRINT_HI;
  endfunction

  // answer of the parser to one request word, advancing the predictor state
  function automatic rsp_word_t parse_word(input req_word_t w);
    rsp_word_t         r;
    parse_state_t      nxt;
    logic [BYTE_W-1:0] c;
    logic              bad;
    r            = '0;
    r.status     = STATUS_PENDING;
    r.line_count = lines_cnt;
    if (w.func == FUNC_READ) begin
      if (w.read_line < MAX_LINES && w.read_col < LINE_SIZE)
        r.read_char = line_mem[int'(w.read_line) * LINE_SIZE + int'(w.read_col)];
      return r;
    end
    c   = w.byte_in;
    nxt = ps;
    bad = 1'b0;
    case (ps)
      PS_AWAIT_CR: begin
        if (c == CH_CR) begin
          col_cnt = '0;
          nxt     = PS_AWAIT_LF;
        end else bad = 1'b1;
      end
      // the opening line break counts as a line, so info starts at row 1
      PS_AWAIT_LF: begin
        if (c == CH_LF) begin
          bump_lines();
          col_cnt = '0;
          nxt     = PS_HEAD;
        end else bad = 1'b1;
      end
      PS_HEAD: begin
        if (c == CH_O) nxt = PS_OK_K;
        else if (c == CH_E) nxt = PS_ERR_R1;
        else if (c == CH_PLUS) nxt = PS_INFO_FIRST;
        else bad = 1'b1;
      end
      PS_OK_K:   if (c == CH_K)  nxt = PS_OK_CR;  else bad = 1'b1;
      PS_OK_CR:  if (c == CH_CR) nxt = PS_OK_LF;  else bad = 1'b1;
      PS_ERR_R1: if (c == CH_R)  nxt = PS_ERR_R2; else bad = 1'b1;
      PS_ERR_R2: if (c == CH_R)  nxt = PS_ERR_O;  else bad = 1'b1;
      PS_ERR_O:  if (c == CH_O)  nxt = PS_ERR_R3; else bad = 1'b1;
      PS_ERR_R3: if (c == CH_R)  nxt = PS_ERR_CR; else bad = 1'b1;
      PS_ERR_CR: if (c == CH_CR) nxt = PS_ERR_LF; else bad = 1'b1;
      PS_OK_LF, PS_ERR_LF: begin
        if (c == CH_LF) begin
          bump_lines();
          r.status     = STATUS_DONE;
          r.final_word = (ps == PS_ERR_LF);
        end else bad = 1'b1;
      end
      PS_INFO_FIRST: begin
        if (is_text(c)) begin
          keep_info_byte(c);
          nxt = PS_INFO_BODY;
        end else bad = 1'b1;
      end
      // with the store full the line is parsed but leaves no terminator and no count
      PS_INFO_BODY: begin
        if (is_text(c)) keep_info_byte(c);
        else if (c == CH_CR) begin
          if (lines_cnt < MAX_LINES) begin
            put_store(int'(lines_cnt) * LINE_SIZE + int'(col_cnt), '0);
            bump_lines();
            col_cnt = '0;
          end
          nxt = PS_INFO_LF;
        end else bad = 1'b1;
      end
      PS_INFO_LF: if (c == CH_LF) nxt = PS_AFTER_INFO; else bad = 1'b1;
      PS_AFTER_INFO: begin
        if (c == CH_PLUS) nxt = PS_INFO_FIRST;
        else if (c == CH_CR) nxt = PS_BLANK_LF;
        else bad = 1'b1;
      end
      PS_BLANK_LF: if (c == CH_LF) nxt = PS_TAIL; else bad = 1'b1;
      PS_TAIL: begin
        if (c == CH_O) nxt = PS_OK_K;
        else if (c == CH_E) nxt = PS_ERR_R1;
        else bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase
    if (bad) r.status = STATUS_BAD;
    r.line_count = lines_cnt;
    // a finished or broken reply sends the parser back to the start; the store stays
    if (r.status == STATUS_PENDING) ps = nxt;
    else begin
      ps        = PS_AWAIT_CR;
      col_cnt   = '0;
      lines_cnt = '0;
    end
    return r;
  endfunction

  // mostly short idle stretches, now and then a long one
  function automatic int idle_len();
    return ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(4, 1);
  endfunction

  // offer one word, wait for the handshake, then record what the parser must answer
  task automatic send_word(input req_word_t w, input bit has_fixed,
                           input rsp_word_t fixed_rsp);
    rsp_word_t pred;
    if (sender_gaps && $urandom_range(3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.func      <= w.func;
    req_ch.byte_in   <= w.byte_in;
    req_ch.read_line <= w.read_line;
    req_ch.read_col  <= w.read_col;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    pred = parse_word(w);
    answers_due.push_back(has_fixed ? fixed_rsp : pred);
    words_sent++;
  endtask

  task automatic feed_byte(input logic [BYTE_W-1:0] b);
    req_word_t w;
    w.func      = FUNC_FEED;
    w.byte_in   = b;
    w.read_line = RLINE_W'($urandom);
    w.read_col  = RCOL_W'($urandom);
    send_word(w, 1'b0, NO_FIXED);
  endtask

  // reads only target entries already written, since the store powers up unknown
  task automatic read_back();
    req_word_t w;
    int        idx;
    idx         = written_idx[$urandom_range(written_idx.size() - 1)];
    w.func      = FUNC_READ;
    w.byte_in   = BYTE_W'($urandom);
    w.read_line = RLINE_W'(idx / LINE_SIZE);
    w.read_col  = RCOL_W'(idx % LINE_SIZE);
    send_word(w, 1'b0, NO_FIXED);
  endtask

  // stop offering and wait for every outstanding answer
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  // one reply with random content; n_info below zero picks the line count at
  // random, long_lines makes the info lines straddle the row size, intact
  // keeps the reply free of damage
  task automatic send_reply(input int n_info, input bit long_lines, input bit intact);
    logic [BYTE_W-1:0] q [$];
    int                len;
    int                roll;
    if (n_info < 0) begin
      roll = $urandom_range(99);
      if (roll < 20) n_info = 0;
      else if (roll < 80) n_info = $urandom_range(7, 1);
      else if (roll < 97) n_info = $urandom_range(12, 8);    // overflows the store
      else n_info = $urandom_range(20, 13);                  // well past the store
    end
    q.push_back(CH_CR);
    q.push_back(CH_LF);
    for (int i = 0; i < n_info; i++) begin
      q.push_back(CH_PLUS);
      if (long_lines) len = LINE_SIZE - 3 + i;
      else if ($urandom_range(29) == 0) len = $urandom_range(LINE_SIZE + 8, LINE_SIZE - 4);
      else len = $urandom_range(12, 1);
      repeat (len) q.push_back(BYTE_W'($urandom_range(PRINT_HI, PRINT_LO)));
      q.push_back(CH_CR);
      q.push_back(CH_LF);
    end
    if (n_info > 0) begin
      q.push_back(CH_CR);
      q.push_back(CH_LF);
    end
    if ($urandom_range(1) == 0) begin
      q.push_back(CH_O);
      q.push_back(CH_K);
    end else begin
      q.push_back(CH_E);
      q.push_back(CH_R);
      q.push_back(CH_R);
      q.push_back(CH_O);
      q.push_back(CH_R);
    end
    q.push_back(CH_CR);
    q.push_back(CH_LF);

    // some replies get damaged: any wrong byte, a misplaced control byte,
    // a cut (the next reply then starts mid-way), or plain line noise
    roll = intact ? 99 : $urandom_range(99);
    if (roll < 6) begin
      q[$urandom_range(q.size() - 1)] = BYTE_W'($urandom);
    end else if (roll < 10) begin
      case ($urandom_range(7))
        0:       q[$urandom_range(q.size() - 1)] = CH_CR;
        1:       q[$urandom_range(q.size() - 1)] = CH_LF;
        2:       q[$urandom_range(q.size() - 1)] = CH_PLUS;
        3:       q[$urandom_range(q.size() - 1)] = CH_O;
        4:       q[$urandom_range(q.size() - 1)] = CH_E;
        5:       q[$urandom_range(q.size() - 1)] = PRINT_LO - 1'b1;
        6:       q[$urandom_range(q.size() - 1)] = PRINT_HI + 1'b1;
        default: q[$urandom_range(q.size() - 1)] = '0;
      endcase
    end else if (roll < 13) begin
      len = $urandom_range(q.size() - 1, 1);
      while (q.size() > len) void'(q.pop_back());
    end else if (roll < 16) begin
      q.delete();
      repeat ($urandom_range(6, 1)) q.push_back(BYTE_W'($urandom));
    end

    // reads of the store are sprinkled between reply bytes
    foreach (q[i]) begin
      if (written_idx.size() != 0 && $urandom_range(11) == 0) read_back();
      feed_byte(q[i]);
    end
  endtask

  // response side: random ready gaps in changing modes, plus one long hold-off
  initial begin : receiver
    int mode_left;
    bit gaps_on;
    mode_left = 0;
    gaps_on   = 1'b0;
    rsp_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        gaps_on   = ($urandom_range(3) != 0);
        mode_left = $urandom_range(300, 50);
      end
      mode_left--;
      if (rsp_hold_req) begin
        // long hold so the internal queue fills and req.ready drops
        rsp_ch.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(posedge clk);
        rsp_hold_req = 1'b0;
        rsp_ch.ready <= 1'b1;
      end else if (gaps_on && $urandom_range(3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // every accepted response word is held against the oldest outstanding answer
  always @(posedge clk) begin : rsp_check
    rsp_word_t want;
    if (rst === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] response word with no answer outstanding: status=%0d count=%0d",
                   $time, rsp_ch.status, rsp_ch.line_count);
      end else begin
        want = answers_due.pop_front();
        if (rsp_ch.status !== want.status || rsp_ch.final_word !== want.final_word ||
            rsp_ch.line_count !== want.line_count || rsp_ch.read_char !== want.read_char)
        begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $write("[%0t] mismatch: expected status=%0d final=%0d count=%0d char=%02h,",
                   $time, want.status, want.final_word, want.line_count, want.read_char);
            $display(" got status=%0d final=%0d count=%0d char=%02h",
                     rsp_ch.status, rsp_ch.final_word, rsp_ch.line_count,
                     rsp_ch.read_char);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int base;
    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.func      <= FUNC_FEED;
    req_ch.byte_in   <= '0;
    req_ch.read_line <= '0;
    req_ch.read_col  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    sender_gaps = 1'b1;
    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].has_fixed, dir_rows[i].r);

    // lines just under, at and over the bytes a row keeps, back to back
    sender_gaps = 1'b0;
    send_reply(4, 1'b1, 1'b1);
    // more lines than rows: the store fills and later lines are only parsed
    sender_gaps = 1'b1;
    send_reply(12, 1'b0, 1'b1);

    // receiver stalls while the sender keeps pushing, then everything drains
    sender_gaps  = 1'b0;
    rsp_hold_req = 1'b1;
    send_reply(6, 1'b0, 1'b1);
    drain();

    // random replies, mostly well formed, some damaged, with occasional pauses
    base = words_sent;
    while (words_sent - base < RANDOM_WORDS) begin
      sender_gaps = ($urandom_range(3) != 0);
      send_reply(-1, 1'b0, 1'b0);
      if ($urandom_range(24) == 0) drain();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** at_response_parser: PASSED **");
    end else begin
      $display("** at_response_parser: FAILED **");
    end
    $finish;
  end

endmodule
